@@ hw/rtl/volume_fade_ramp_engine_core_assert.svh @@
// Assertion shorthands for the fade engine checker.
// Both expect clk and rst_n in scope; checks are off while reset is held.
`ifndef VOLUME_FADE_RAMP_ENGINE_CORE_ASSERT_SVH
`define VOLUME_FADE_RAMP_ENGINE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define VFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/vfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vfr_pkg;

    localparam int LEVEL_W   = 16;
    localparam int TIME_W    = 24;
    localparam int DT_W      = 16;
    localparam int OP_W      = 3;
    localparam int CURVE_W   = 2;
    localparam int T_W       = 16;   // fraction bits of normalised time
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 64;
    localparam int S_USER_W  = OP_W;
    localparam int M_DATA_W  = 40;

    // result transaction layout
    localparam int OUT_LEVEL_LSB  = 0;
    localparam int OUT_LEVEL_MSB  = OUT_LEVEL_LSB + LEVEL_W - 1;
    localparam int OUT_GAIN_LSB   = OUT_LEVEL_MSB + 1;
    localparam int OUT_GAIN_MSB   = OUT_GAIN_LSB + LEVEL_W - 1;
    localparam int OUT_FADING_BIT = OUT_GAIN_MSB + 1;
    localparam int OUT_ON_BIT     = OUT_FADING_BIT + 1;
    localparam int OUT_DONE_BIT   = OUT_ON_BIT + 1;
    localparam int OUT_ACC_BIT    = OUT_DONE_BIT + 1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_PLAY     = 3'd1,
        OP_FADE_TO  = 3'd2,
        OP_FADE_OUT = 3'd3,
        OP_CANCEL   = 3'd4,
        OP_STOP     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_IN   = 2'd1,
        MODE_OUT  = 2'd2
    } fade_mode_t;

    typedef enum logic [CURVE_W-1:0] {
        CURVE_LINEAR   = 2'd0,
        CURVE_EASE_IN  = 2'd1,
        CURVE_EASE_OUT = 2'd2,
        CURVE_SMOOTH   = 2'd3
    } curve_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASTER_GAIN   = 1'b0,
        CFG_CATEGORY_GAIN = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MUL_SQUARE,
        MUL_SHAPE,
        MUL_LEVEL,
        MUL_GAIN_CAT,
        MUL_GAIN_MST
    } mul_op_t;

    typedef struct packed {
        logic    load;      // take the input transaction, apply command
        logic    div_step;  // one restoring divide step
        logic    mul_en;    // one pass through the shared multiplier
        mul_op_t mul_op;
        logic    res_load;  // capture the result register
    } dp_cmd_t;

    typedef struct packed {
        logic need_interp;  // tick lands mid-fade: curve sequence required
    } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/volume_fade_ramp_engine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Single-channel gain fade engine.
// Slave channel: one command transaction per beat; s_tuser carries the
// operation (tick, play, fade to target, fade out and stop, cancel, stop),
// s_tdata its arguments. Master channel: exactly one result transaction per
// command with the new level, effective gain and status flags.
// Gain registers are written through cfg_we/cfg_index/cfg_wdata; the user
// writes them only while the engine is idle, which the block itself does not
// enforce. Both reset to full scale.
// Sequence from accept to result valid (output register free):
//   tick inside a running fade : 16 restoring divide steps for
//                                t = elapsed/length, five passes through the
//                                single shared multiplier (square, curve,
//                                level, two gain scalings), one result load
//   every other command        : two gain passes, result load
// One command in flight at a time; s_tready returns the cycle after the result
// load. The next command is taken while the receiver has not yet consumed the
// result; a second result waits in the controller until m_tready drains the
// first. Reset clears the channel (off, no fade, level 0) with m_tvalid low.

module volume_fade_ramp_engine_core
    import vfr_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    // slave side
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // delta_time[15:0], target_level[31:16], fade_duration[55:32],
    // curve_select[57:56], allow_interrupt[58], zero pad [63:59]
    input  wire  [S_DATA_W-1:0]   s_tdata,
    // operation[2:0]
    input  wire  [S_USER_W-1:0]   s_tuser,
    // master side
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // level_out[15:0], effective_gain[31:16], fading[32], channel_on[33],
    // fade_done[34], accepted[35], zero pad [39:36]
    output logic [M_DATA_W-1:0]   m_tdata,
    // configuration: 0 master_gain, 1 category_gain
    input  wire                   cfg_we,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [LEVEL_W-1:0]    cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: accept, divide count, multiplier schedule, output handshake
    vfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // fade state, divider, shared multiplier and result register
    vfr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ hw/rtl/vfr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vfr_ctrl
    import vfr_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire             m_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam int CNT_W = $clog2(T_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQUARE,
        ST_SHAPE,
        ST_LEVEL,
        ST_GAIN_CAT,
        ST_GAIN_MST,
        ST_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '{load: 1'b0, div_step: 1'b0, mul_en: 1'b0,
                       mul_op: MUL_SQUARE, res_load: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(T_W - 1);
                    state_next = status.need_interp ? ST_DIV : ST_GAIN_CAT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SQUARE;
                state_next = ST_SHAPE;
            end
            ST_SHAPE:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SHAPE;
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_LEVEL;
                state_next = ST_GAIN_CAT;
            end
            ST_GAIN_CAT:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_GAIN_CAT;
                state_next = ST_GAIN_MST;
            end
            ST_GAIN_MST:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_GAIN_MST;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || m_tready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/vfr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vfr_datapath
    import vfr_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [LEVEL_W-1:0]     cfg_wdata,
    input  wire  [S_DATA_W-1:0]    s_tdata,
    input  wire  [S_USER_W-1:0]    s_tuser,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    output logic [M_DATA_W-1:0]    m_tdata
);

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;
    localparam logic [T_W:0]       ONE_Q      = 17'h10000;
    localparam logic [17:0]        TWO_Q      = 18'd131072;
    localparam logic [17:0]        THREE_Q    = 18'd196608;
    localparam int                 PROD_W     = 35;

    // Q0.16 product by the gain scale: (p + FULL/2) / FULL, clamped.
    // Divide by 2^16-1 done as shift plus a single correction.
    function automatic logic [LEVEL_W-1:0] qscale(input logic [2*LEVEL_W-1:0] p);
        logic [2*LEVEL_W:0]   x;
        logic [LEVEL_W:0]     q0;
        logic [LEVEL_W+1:0]   r;
        logic [LEVEL_W+1:0]   q;
        x  = {1'b0, p} + (2*LEVEL_W+1)'(LEVEL_FULL >> 1);
        q0 = x[2*LEVEL_W:LEVEL_W];
        r  = {2'b00, x[LEVEL_W-1:0]} + {1'b0, q0};
        q  = {1'b0, q0} + (LEVEL_W+2)'(r >= (LEVEL_W+2)'(LEVEL_FULL));
        return (q > (LEVEL_W+2)'(LEVEL_FULL)) ? LEVEL_FULL : q[LEVEL_W-1:0];
    endfunction

    // input unpacking
    op_t                 in_op;
    logic [DT_W-1:0]     in_dt;
    logic [LEVEL_W-1:0]  in_tgt;
    logic [TIME_W-1:0]   in_dur;
    curve_t              in_curve;
    logic                in_intr;

    assign in_op    = op_t'(s_tuser);
    assign in_dt    = s_tdata[DT_W-1:0];
    assign in_tgt   = s_tdata[DT_W+LEVEL_W-1:DT_W];
    assign in_dur   = s_tdata[DT_W+LEVEL_W+TIME_W-1:DT_W+LEVEL_W];
    assign in_curve = curve_t'(s_tdata[DT_W+LEVEL_W+TIME_W+CURVE_W-1:DT_W+LEVEL_W+TIME_W]);
    assign in_intr  = s_tdata[DT_W+LEVEL_W+TIME_W+CURVE_W];

    // configuration
    logic [LEVEL_W-1:0] master_reg, category_reg;

    // fade state
    logic               active_reg, active_next;
    fade_mode_t         mode_reg, mode_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] start_reg, start_next;
    logic [LEVEL_W-1:0] goal_reg, goal_next;
    logic [TIME_W-1:0]  length_reg, length_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    curve_t             curve_reg, curve_next;
    logic               intr_reg, intr_next;
    logic               stop_reg, stop_next;
    logic               done_reg, done_next;
    logic               acc_reg, acc_next;

    // working registers
    logic [TIME_W:0]    rem_reg;
    logic [T_W-1:0]     quot_reg;
    logic [T_W-1:0]     sq_reg;
    logic [T_W:0]       c_reg;
    logic [LEVEL_W-1:0] gain_reg;
    logic [M_DATA_W-1:0] out_reg;

    logic [TIME_W:0]    e_sum;
    logic               e_snap;
    logic [TIME_W-1:0]  e_sat;
    logic               locked;

    assign e_sum  = {1'b0, elapsed_reg} + (TIME_W+1)'(in_dt);
    assign e_snap = (e_sum >= {1'b0, length_reg});
    assign e_sat  = e_snap ? length_reg : e_sum[TIME_W-1:0];
    assign locked = (mode_reg != MODE_NONE) && !intr_reg;

    assign status.need_interp = (in_op == OP_TICK) && active_reg &&
                                (mode_reg != MODE_NONE) && !e_snap;

    // shared multiplier
    logic [T_W:0]        mul_a;
    logic [17:0]         mul_b;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   prod_rnd;
    logic [PROD_W-17:0]  rnd_hi;
    logic                goal_up;
    logic [LEVEL_W-1:0]  diff;
    logic [PROD_W-17:0]  shape_raw;
    logic [T_W:0]        shape_c;

    assign goal_up = (goal_reg >= start_reg);
    assign diff    = goal_up ? (goal_reg - start_reg) : (start_reg - goal_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_SQUARE:
            begin
                mul_a = {1'b0, quot_reg};
                mul_b = 18'(quot_reg);
            end
            MUL_SHAPE:
            begin
                if (curve_reg == CURVE_EASE_OUT)
                begin
                    mul_a = {1'b0, quot_reg};
                    mul_b = TWO_Q - 18'(quot_reg);
                end
                else
                begin
                    mul_a = {1'b0, sq_reg};
                    mul_b = THREE_Q - 18'({quot_reg, 1'b0});
                end
            end
            MUL_LEVEL:
            begin
                mul_a = c_reg;
                mul_b = 18'(diff);
            end
            MUL_GAIN_CAT:
            begin
                mul_a = 17'(level_reg);
                mul_b = 18'(category_reg);
            end
            MUL_GAIN_MST:
            begin
                mul_a = 17'(gain_reg);
                mul_b = 18'(master_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_rnd = prod + PROD_W'(32768);
    assign rnd_hi   = prod_rnd[PROD_W-1:16];

    always_comb
    begin
        case (curve_reg)
            CURVE_LINEAR:  shape_raw = (PROD_W-16)'(quot_reg);
            CURVE_EASE_IN: shape_raw = (PROD_W-16)'(sq_reg);
            default:       shape_raw = rnd_hi;
        endcase
        shape_c = (shape_raw > (PROD_W-16)'(ONE_Q)) ? ONE_Q : shape_raw[T_W:0];
    end

    // command decode and fade state update
    always_comb
    begin
        active_next  = active_reg;
        mode_next    = mode_reg;
        level_next   = level_reg;
        start_next   = start_reg;
        goal_next    = goal_reg;
        length_next  = length_reg;
        elapsed_next = elapsed_reg;
        curve_next   = curve_reg;
        intr_next    = intr_reg;
        stop_next    = stop_reg;
        done_next    = done_reg;
        acc_next     = acc_reg;

        if (cmd.load)
        begin
            done_next = 1'b0;
            acc_next  = 1'b1;
            case (in_op)
                OP_TICK:
                begin
                    if (active_reg && (mode_reg != MODE_NONE))
                    begin
                        elapsed_next = e_sat;
                        if (e_snap)
                        begin
                            level_next = goal_reg;
                            done_next  = 1'b1;
                            if (stop_reg)
                            begin
                                active_next = 1'b0;
                            end
                            mode_next = MODE_NONE;
                            stop_next = 1'b0;
                            intr_next = 1'b0;
                        end
                    end
                end
                OP_PLAY:
                begin
                    active_next = 1'b1;
                    if (in_dur == '0)
                    begin
                        level_next = in_tgt;
                        mode_next  = MODE_NONE;
                        stop_next  = 1'b0;
                        intr_next  = 1'b0;
                    end
                    else
                    begin
                        // fade-in always starts from silence
                        level_next   = '0;
                        start_next   = '0;
                        goal_next    = in_tgt;
                        mode_next    = MODE_IN;
                        length_next  = in_dur;
                        elapsed_next = '0;
                        curve_next   = in_curve;
                        intr_next    = in_intr;
                        stop_next    = 1'b0;
                    end
                end
                OP_FADE_TO:
                begin
                    if (!active_reg || locked)
                    begin
                        acc_next = 1'b0;
                    end
                    else if (in_dur == '0)
                    begin
                        level_next = in_tgt;
                        mode_next  = MODE_NONE;
                        stop_next  = 1'b0;
                        intr_next  = 1'b0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        start_next   = level_reg;
                        goal_next    = in_tgt;
                        mode_next    = (in_tgt > level_reg) ? MODE_IN : MODE_OUT;
                        length_next  = in_dur;
                        elapsed_next = '0;
                        curve_next   = in_curve;
                        intr_next    = in_intr;
                        stop_next    = 1'b0;
                    end
                end
                OP_FADE_OUT:
                begin
                    if (!active_reg)
                    begin
                        acc_next = 1'b0;
                    end
                    else if (in_dur == '0)
                    begin
                        // instant stop overrides even a locked fade
                        active_next = 1'b0;
                        mode_next   = MODE_NONE;
                        stop_next   = 1'b0;
                        intr_next   = 1'b0;
                        done_next   = 1'b1;
                    end
                    else if (locked)
                    begin
                        acc_next = 1'b0;
                    end
                    else
                    begin
                        start_next   = level_reg;
                        goal_next    = '0;
                        mode_next    = MODE_OUT;
                        length_next  = in_dur;
                        elapsed_next = '0;
                        curve_next   = in_curve;
                        intr_next    = in_intr;
                        stop_next    = 1'b1;
                    end
                end
                OP_CANCEL:
                begin
                    mode_next = MODE_NONE;
                    stop_next = 1'b0;
                    intr_next = 1'b0;
                end
                OP_STOP:
                begin
                    active_next = 1'b0;
                    mode_next   = MODE_NONE;
                    stop_next   = 1'b0;
                    intr_next   = 1'b0;
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
        else if (cmd.mul_en && (cmd.mul_op == MUL_LEVEL))
        begin
            level_next = goal_up ? (start_reg + rnd_hi[LEVEL_W-1:0])
                                 : (start_reg - rnd_hi[LEVEL_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg   <= LEVEL_FULL;
            category_reg <= LEVEL_FULL;
            active_reg   <= 1'b0;
            mode_reg     <= MODE_NONE;
            level_reg    <= '0;
            start_reg    <= '0;
            goal_reg     <= '0;
            length_reg   <= '0;
            elapsed_reg  <= '0;
            curve_reg    <= CURVE_LINEAR;
            intr_reg     <= 1'b0;
            stop_reg     <= 1'b0;
            done_reg     <= 1'b0;
            acc_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_MASTER_GAIN))
            begin
                master_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == CFG_CATEGORY_GAIN))
            begin
                category_reg <= cfg_wdata;
            end
            active_reg  <= active_next;
            mode_reg    <= mode_next;
            level_reg   <= level_next;
            start_reg   <= start_next;
            goal_reg    <= goal_next;
            length_reg  <= length_next;
            elapsed_reg <= elapsed_next;
            curve_reg   <= curve_next;
            intr_reg    <= intr_next;
            stop_reg    <= stop_next;
            done_reg    <= done_next;
            acc_reg     <= acc_next;
        end
    end

    // divider, multiplier results and output register: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg  <= e_sum;
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            // restoring step; remainder stays below the fade length
            if ({rem_reg[TIME_W-1:0], 1'b0} >= {1'b0, length_reg})
            begin
                rem_reg  <= {rem_reg[TIME_W-1:0], 1'b0} - {1'b0, length_reg};
                quot_reg <= {quot_reg[T_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[TIME_W-1:0], 1'b0};
                quot_reg <= {quot_reg[T_W-2:0], 1'b0};
            end
        end

        if (cmd.mul_en)
        begin
            case (cmd.mul_op)
                MUL_SQUARE:   sq_reg   <= rnd_hi[T_W-1:0];
                MUL_SHAPE:    c_reg    <= shape_c;
                MUL_GAIN_CAT: gain_reg <= qscale(prod[2*LEVEL_W-1:0]);
                MUL_GAIN_MST: gain_reg <= qscale(prod[2*LEVEL_W-1:0]);
                default:      c_reg    <= c_reg;
            endcase
        end

        if (cmd.res_load)
        begin
            out_reg                              <= '0;
            out_reg[OUT_LEVEL_MSB:OUT_LEVEL_LSB] <= level_reg;
            out_reg[OUT_GAIN_MSB:OUT_GAIN_LSB]   <= active_reg ? gain_reg : '0;
            out_reg[OUT_FADING_BIT]              <= (mode_reg != MODE_NONE);
            out_reg[OUT_ON_BIT]                  <= active_reg;
            out_reg[OUT_DONE_BIT]                <= done_reg;
            out_reg[OUT_ACC_BIT]                 <= acc_reg;
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/vfr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "volume_fade_ramp_engine_core_assert.svh"

module vfr_checker
    import vfr_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  s_tvalid,
    input wire                  s_tready,
    input wire                  m_tvalid,
    input wire                  m_tready,
    input wire [M_DATA_W-1:0]   m_tdata
);

    `VFR_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    `VFR_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second command taken while one is in flight")

    `VFR_ASSERT_SAME(a_gain_when_off, m_tvalid && !m_tdata[OUT_ON_BIT], m_tdata[OUT_GAIN_MSB:OUT_GAIN_LSB] == '0, "non-zero gain on a stopped channel")

    `VFR_ASSERT_SAME(a_fade_needs_on, m_tvalid && m_tdata[OUT_FADING_BIT], m_tdata[OUT_ON_BIT], "fade reported on a stopped channel")

    `VFR_ASSERT_SAME(a_done_ends_fade, m_tvalid && m_tdata[OUT_DONE_BIT], !m_tdata[OUT_FADING_BIT], "done pulse while still fading")

endmodule

bind volume_fade_ramp_engine_core vfr_checker u_checker (.*);

`default_nettype wire
